@@ design/pec15cgr_pkg.sv @@
`default_nettype none

package pec15cgr_pkg;

  // Group layout
  localparam int CellsPerGroup = 3;
  localparam int GroupCount    = 2;
  localparam int DataLen       = 2 * CellsPerGroup;   // data bytes per group
  localparam int LastPos       = DataLen + 1;         // position of the PEC low byte
  localparam int StoreDepth    = 7;

  // PEC15 constants
  localparam logic [15:0] PecSeed = 16'd16;
  localparam logic [15:0] PecPoly = 16'h4599;

  typedef logic [2:0] pos_t;
  typedef logic [2:0] group_t;

  // One finished group, as handed from the assembler to the output register
  typedef struct packed {
    logic        done;
    group_t      group_index;
    logic [15:0] cell_a;
    logic [15:0] cell_b;
    logic [15:0] cell_c;
    logic        pec_ok;
  } result_t;

  // Byte-wise CRC15 table entry for address a (eight shift steps).
  function automatic logic [15:0] pec_table_entry(input logic [7:0] a);
    logic [15:0] r;
    r = {1'b0, a, 7'b0};
    for (int k = 0; k < 8; k++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PecPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/pec15cgr_assembler.sv @@
`default_nettype none

module pec15cgr_assembler (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 new_scan,
  output pec15cgr_pkg::result_t     result
);

  localparam pec15cgr_pkg::pos_t   LastPosC = pec15cgr_pkg::pos_t'(pec15cgr_pkg::LastPos);
  localparam pec15cgr_pkg::pos_t   DataLenC = pec15cgr_pkg::pos_t'(pec15cgr_pkg::DataLen);
  localparam pec15cgr_pkg::group_t GroupMax =
    pec15cgr_pkg::group_t'(pec15cgr_pkg::GroupCount - 1);

  pec15cgr_pkg::pos_t   byte_position, byte_position_next;
  pec15cgr_pkg::group_t group_counter, group_counter_next;
  logic [15:0]          crc_remainder, crc_remainder_next;
  logic [7:0]           data_bytes [pec15cgr_pkg::StoreDepth];

  pec15cgr_pkg::pos_t   pos;
  pec15cgr_pkg::group_t group_cur;
  logic [15:0]          crc_cur;
  logic [7:0]           crc_addr;
  logic [15:0]          crc_step;
  logic [15:0]          pec_calc;
  logic [15:0]          pec_rx;
  logic                 last_byte;

  // new_scan restarts the pass before this byte is taken
  always_comb begin
    pos       = new_scan ? '0 : byte_position;
    group_cur = new_scan ? '0 : group_counter;
    crc_cur   = new_scan ? pec15cgr_pkg::PecSeed : crc_remainder;
    last_byte = (pos == LastPosC);
    crc_addr  = crc_cur[14:7] ^ rx_byte;
    crc_step  = {crc_cur[7:0], 8'h00} ^ pec15cgr_pkg::pec_table_entry(crc_addr);
    pec_calc  = {crc_cur[14:0], 1'b0};
    pec_rx    = {data_bytes[DataLenC], rx_byte};
  end

  always_comb begin
    byte_position_next = pos + 3'd1;
    group_counter_next = group_cur;
    crc_remainder_next = (pos < DataLenC) ? crc_step : crc_cur;
    if (last_byte) begin
      byte_position_next = '0;
      crc_remainder_next = pec15cgr_pkg::PecSeed;
      group_counter_next = (group_cur >= GroupMax) ? '0 : group_cur + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      group_counter <= '0;
      crc_remainder <= pec15cgr_pkg::PecSeed;
    end else if (accept) begin
      byte_position <= byte_position_next;
      group_counter <= group_counter_next;
      crc_remainder <= crc_remainder_next;
    end
  end

  // Byte store: filled in order, read only at fixed places
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      data_bytes[pos] <= rx_byte;
    end
  end

  always_comb begin
    result.done        = accept && last_byte;
    result.group_index = group_cur;
    result.cell_a      = {data_bytes[1], data_bytes[0]};
    result.cell_b      = (pec15cgr_pkg::CellsPerGroup > 1) ?
                         {data_bytes[3], data_bytes[2]} : 16'h0000;
    result.cell_c      = (pec15cgr_pkg::CellsPerGroup > 2) ?
                         {data_bytes[5], data_bytes[4]} : 16'h0000;
    result.pec_ok      = (pec_calc == pec_rx);
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LastPosC)
    else $error("byte position past the PEC byte");

  a_group_range: assert property (@(posedge clk) disable iff (rst)
    group_counter <= GroupMax)
    else $error("group counter out of range");

  a_restart_after_done: assert property (@(posedge clk) disable iff (rst)
    result.done |=> (byte_position == '0) && (crc_remainder == pec15cgr_pkg::PecSeed))
    else $error("group not restarted after result");

endmodule

`default_nettype wire

@@ design/pec15_cell_group_receiver_unit.sv @@
`default_nettype none

// Channel   Dir  Beat contents
// s_axis    in   s_tdata[7:0] = rx_byte, s_tuser = new_scan
// m_axis    out  s_tdata-style: group_index, cell_a, cell_b, cell_c; m_tuser = pec_ok
//
// One byte is taken per cycle while s_tready is high; the CRC update is one table lookup and XOR per beat.
// A result appears on m_* the cycle after the last PEC byte of a group is taken.
// The single output register lets a new byte in while a result waits, as long
// as the slot is empty or being drained; s_tready drops only when it is full and stalled.
// rst is synchronous: byte position and group counter clear, the CRC returns to the seed and m_tvalid drops.
module pec15_cell_group_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] new_scan
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [2:0] group_index, [18:3] cell_a,
                                      // [34:19] cell_b, [50:35] cell_c, [55:51] zero
  output logic             m_tuser    // [0] pec_ok
);

  pec15cgr_pkg::result_t result;
  logic                  accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  pec15cgr_assembler u_assembler (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (s_tdata),
    .new_scan (s_tuser),
    .result   (result)
  );

  // Output register: load on a finished group, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.done) begin
      m_tdata <= {5'b0, result.cell_c, result.cell_b, result.cell_a, result.group_index};
      m_tuser <= result.pec_ok;
    end
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(result.done))
    else $error("result shown without a finished group");

  a_done_needs_room: assert property (@(posedge clk) disable iff (rst)
    result.done |-> (!m_tvalid || m_tready))
    else $error("finished group would overwrite a waiting result");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    result.done |=> m_tvalid)
    else $error("finished group not presented");

endmodule

`default_nettype wire
